// ----- hw/rtl/ibct_pkg.sv -----
// Shared types and constants for the in-flight batch completion tracker.
`timescale 1ns / 1ps

package ibct_pkg;

    localparam int RING_DEPTH = 16;
    localparam int TAG_W      = 4;
    localparam int CNT_W      = 5;
    localparam int SEQ_W      = 64;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;

    localparam logic [OP_W-1:0] OP_SUBMIT   = 2'd0;
    localparam logic [OP_W-1:0] OP_COMPLETE = 2'd1;
    localparam logic [OP_W-1:0] OP_TRUNCATE = 2'd2;

    localparam logic [STATUS_W-1:0] CS_FAILURE  = 2'd1;
    localparam logic [STATUS_W-1:0] CS_RESERVED = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RETIRE,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic             push;
        logic [TAG_W-1:0] push_tag;
        logic             mark;
        logic [TAG_W-1:0] mark_tag;
        logic             mark_sync;
        logic             pop;
        logic [TAG_W-1:0] head_tag;
    } t_slot_cmd;

    typedef struct packed {
        logic tag_live;
        logic head_valid;
        logic head_wdone;
        logic head_sdone;
    } t_slot_stat;

endpackage

// ----- hw/rtl/ibct_if.sv -----
// Request and response channel interfaces of the completion tracker.
`timescale 1ns / 1ps

interface ibct_req_if;
    logic                              valid;
    logic                              ready;
    logic [ibct_pkg::OP_W-1:0]         opcode;
    logic [ibct_pkg::SEQ_W-1:0]        end_seq;
    logic [ibct_pkg::TAG_W-1:0]        slot_tag;
    logic                              is_sync;
    logic [ibct_pkg::STATUS_W-1:0]     completion_status;

    modport source (output valid, opcode, end_seq, slot_tag, is_sync, completion_status,
                    input ready);
    modport sink   (input valid, opcode, end_seq, slot_tag, is_sync, completion_status,
                    output ready);
endinterface

interface ibct_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              accepted;
    logic [ibct_pkg::TAG_W-1:0]        assigned_tag;
    logic [ibct_pkg::SEQ_W-1:0]        written_mark;
    logic [ibct_pkg::SEQ_W-1:0]        durable_mark;
    logic [ibct_pkg::CNT_W-1:0]        inflight_count;
    logic                              error_flag;

    modport source (output valid, accepted, assigned_tag, written_mark, durable_mark,
                    inflight_count, error_flag, input ready);
    modport sink   (input valid, accepted, assigned_tag, written_mark, durable_mark,
                    inflight_count, error_flag, output ready);
endinterface

// ----- hw/rtl/ibct_slot_store.sv -----
// Slot ring storage: per-slot status flags and end sequence numbers.
`timescale 1ns / 1ps

module ibct_slot_store (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ibct_pkg::t_slot_cmd         i_cmd,
    input  logic [ibct_pkg::SEQ_W-1:0]  i_push_seq,
    output ibct_pkg::t_slot_stat        o_stat,
    output logic [ibct_pkg::SEQ_W-1:0]  o_head_seq
);

    logic [ibct_pkg::RING_DEPTH-1:0] r_valid;
    logic [ibct_pkg::RING_DEPTH-1:0] r_wdone;
    logic [ibct_pkg::RING_DEPTH-1:0] r_sdone;
    logic [ibct_pkg::SEQ_W-1:0]      r_seq [ibct_pkg::RING_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_wdone <= '0;
            r_sdone <= '0;
        end else begin
            if (i_cmd.push) begin
                r_valid[i_cmd.push_tag] <= 1'b1;
                r_wdone[i_cmd.push_tag] <= 1'b0;
                r_sdone[i_cmd.push_tag] <= 1'b0;
            end
            if (i_cmd.mark && r_valid[i_cmd.mark_tag]) begin
                if (i_cmd.mark_sync) begin
                    r_sdone[i_cmd.mark_tag] <= 1'b1;
                end else begin
                    r_wdone[i_cmd.mark_tag] <= 1'b1;
                end
            end
            if (i_cmd.pop) begin
                r_valid[i_cmd.head_tag] <= 1'b0;
                r_wdone[i_cmd.head_tag] <= 1'b0;
                r_sdone[i_cmd.head_tag] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_seq[i_cmd.push_tag] <= i_push_seq;
        end
    end

    assign o_stat.tag_live   = r_valid[i_cmd.mark_tag];
    assign o_stat.head_valid = r_valid[i_cmd.head_tag];
    assign o_stat.head_wdone = r_wdone[i_cmd.head_tag];
    assign o_stat.head_sdone = r_sdone[i_cmd.head_tag];
    assign o_head_seq        = r_seq[i_cmd.head_tag];

endmodule

// ----- hw/rtl/inflight_batch_completion_tracker.sv -----
// Top level of the in-flight batch completion tracker.
//
//   channel   dir  handshake      payload
//   i_req     in   valid/ready    opcode, end_seq, slot_tag, is_sync, completion_status
//   o_rsp     out  valid/ready    accepted, assigned_tag, written_mark, durable_mark,
//                                 inflight_count, error_flag
//   i_cfg_*   in   write enable   inflight_limit
//
// Submit, truncate and unknown opcodes pass from acceptance through ST_RESP into the
// result register; a completion passes through ST_RETIRE first, where the retire step
// checks one head slot per cycle and stops at the first slot that is not fully done.
// Reset clears all slot flags, pointers, marks and the sticky error at once.
// The result register holds while o_rsp is stalled; a new item is taken once it
// is free or drained in the same cycle, and never while an item is at work.
`timescale 1ns / 1ps

module inflight_batch_completion_tracker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ibct_pkg::CNT_W-1:0] i_cfg_wdata,
    ibct_req_if.sink                   i_req,
    ibct_rsp_if.source                 o_rsp
);

    ibct_pkg::t_state   r_state, n_state;
    logic [ibct_pkg::TAG_W-1:0] r_head, n_head;
    logic [ibct_pkg::TAG_W-1:0] r_tail, n_tail;
    logic [ibct_pkg::CNT_W-1:0] r_live, n_live;
    logic [ibct_pkg::SEQ_W-1:0] r_written, n_written;
    logic [ibct_pkg::SEQ_W-1:0] r_durable, n_durable;
    logic                       r_err, n_err;
    logic                       r_acc, n_acc;
    logic [ibct_pkg::TAG_W-1:0] r_atag, n_atag;
    logic [ibct_pkg::CNT_W-1:0] r_limit;
    logic                       r_out_valid;
    logic                       load;
    logic                       in_ready;
    logic                       in_fire;
    logic                       full;
    logic                       limited;

    logic                       r_o_acc;
    logic [ibct_pkg::TAG_W-1:0] r_o_tag;
    logic [ibct_pkg::SEQ_W-1:0] r_o_written;
    logic [ibct_pkg::SEQ_W-1:0] r_o_durable;
    logic [ibct_pkg::CNT_W-1:0] r_o_live;
    logic                       r_o_err;

    ibct_pkg::t_slot_cmd        cmd;
    ibct_pkg::t_slot_stat       stat;
    logic [ibct_pkg::SEQ_W-1:0] head_seq;

    ibct_slot_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_push_seq (i_req.end_seq),
        .o_stat     (stat),
        .o_head_seq (head_seq)
    );

    function automatic logic [ibct_pkg::TAG_W-1:0] next_slot(
        input logic [ibct_pkg::TAG_W-1:0] p
    );
        return (p == ibct_pkg::TAG_W'(ibct_pkg::RING_DEPTH - 1)) ?
            '0 : p + ibct_pkg::TAG_W'(1);
    endfunction

    assign in_ready = (r_state == ibct_pkg::ST_IDLE) && (!r_out_valid || o_rsp.ready);
    assign in_fire  = i_req.valid && in_ready;
    assign full     = r_live >= ibct_pkg::CNT_W'(ibct_pkg::RING_DEPTH);
    assign limited  = (r_limit != '0) && (r_live >= r_limit);

    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_tail        = r_tail;
        n_live        = r_live;
        n_written     = r_written;
        n_durable     = r_durable;
        n_err         = r_err;
        n_acc         = r_acc;
        n_atag        = r_atag;
        load          = 1'b0;
        cmd           = '0;
        cmd.push_tag  = r_tail;
        cmd.mark_tag  = i_req.slot_tag;
        cmd.mark_sync = i_req.is_sync;
        cmd.head_tag  = r_head;

        unique case (r_state)
            ibct_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_acc   = 1'b0;
                    n_atag  = '0;
                    n_state = ibct_pkg::ST_RESP;
                    unique case (i_req.opcode)
                        ibct_pkg::OP_SUBMIT: begin
                            if (!full && !limited) begin
                                cmd.push  = 1'b1;
                                n_tail    = next_slot(r_tail);
                                n_live    = r_live + ibct_pkg::CNT_W'(1);
                                n_written = i_req.end_seq;
                                n_acc     = 1'b1;
                                n_atag    = r_tail;
                            end
                        end
                        ibct_pkg::OP_COMPLETE: begin
                            // error is raised before the slot lookup
                            if (i_req.completion_status == ibct_pkg::CS_FAILURE ||
                                i_req.completion_status == ibct_pkg::CS_RESERVED) begin
                                n_err = 1'b1;
                            end
                            if (stat.tag_live) begin
                                cmd.mark = 1'b1;
                                n_acc    = 1'b1;
                            end
                            n_state = ibct_pkg::ST_RETIRE;
                        end
                        ibct_pkg::OP_TRUNCATE: begin
                            n_written = '0;
                            n_durable = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ibct_pkg::ST_RETIRE: begin
                // check one head slot per cycle; stop at the first not fully done
                if (r_live != '0 && stat.head_valid && stat.head_wdone) begin
                    n_written = head_seq;
                    if (stat.head_sdone) begin
                        n_durable = head_seq;
                        cmd.pop   = 1'b1;
                        n_head    = next_slot(r_head);
                        n_live    = r_live - ibct_pkg::CNT_W'(1);
                    end else begin
                        n_state = ibct_pkg::ST_RESP;
                    end
                end else begin
                    n_state = ibct_pkg::ST_RESP;
                end
            end
            ibct_pkg::ST_RESP: begin
                load    = 1'b1;
                n_state = ibct_pkg::ST_IDLE;
            end
            default: begin
                n_state = ibct_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ibct_pkg::ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_live      <= '0;
            r_written   <= '0;
            r_durable   <= '0;
            r_err       <= 1'b0;
            r_acc       <= 1'b0;
            r_atag      <= '0;
            r_limit     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_live    <= n_live;
            r_written <= n_written;
            r_durable <= n_durable;
            r_err     <= n_err;
            r_acc     <= n_acc;
            r_atag    <= n_atag;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_acc     <= r_acc;
            r_o_tag     <= r_atag;
            r_o_written <= r_written;
            r_o_durable <= r_durable;
            r_o_live    <= r_live;
            r_o_err     <= r_err;
        end
    end

    assign i_req.ready          = in_ready;
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.accepted       = r_o_acc;
    assign o_rsp.assigned_tag   = r_o_tag;
    assign o_rsp.written_mark   = r_o_written;
    assign o_rsp.durable_mark   = r_o_durable;
    assign o_rsp.inflight_count = r_o_live;
    assign o_rsp.error_flag     = r_o_err;

endmodule

// ----- bench/tb_inflight_batch_completion_tracker.sv -----
// Testbench for the in-flight batch completion tracker: directed rows, then random phases.
`timescale 1ns / 1ps

module tb_inflight_batch_completion_tracker;

    localparam int CYCLE_LIMIT     = 300000;
    localparam int HOLD_CYCLES     = 120;
    localparam int SETTLE_CYCLES   = 2 * (ibct_pkg::RING_DEPTH + 3);
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int DUE_DEPTH       = 8;
    localparam int SCRIPT_DEPTH    = 40;

    localparam logic [ibct_pkg::OP_W-1:0]     OP_UNUSED    = 2'd3;
    localparam logic [ibct_pkg::STATUS_W-1:0] CS_SUCCESS   = 2'd0;
    localparam logic [ibct_pkg::STATUS_W-1:0] CS_CANCELLED = 2'd2;

    localparam int F_VALID = 0;
    localparam int F_WDONE = 1;
    localparam int F_SDONE = 2;

    localparam logic [ibct_pkg::SEQ_W-1:0] SEQ_ONES = '1;

    typedef struct packed {
        logic [ibct_pkg::OP_W-1:0]     op;
        logic [ibct_pkg::SEQ_W-1:0]    end_seq;
        logic [ibct_pkg::TAG_W-1:0]    tag;
        logic                          sync;
        logic [ibct_pkg::STATUS_W-1:0] st;
    } t_batch_req;

    typedef struct packed {
        logic                       accepted;
        logic [ibct_pkg::TAG_W-1:0] tag;
        logic [ibct_pkg::SEQ_W-1:0] written;
        logic [ibct_pkg::SEQ_W-1:0] durable;
        logic [ibct_pkg::CNT_W-1:0] inflight;
        logic                       err;
    } t_track_status;

    typedef struct {
        bit                         is_cfg;
        logic [ibct_pkg::CNT_W-1:0] limit;
        t_batch_req                 req;
        bit                         typed;
        t_track_status              want;
    } t_script_row;

    localparam t_track_status ALL_CLEAR = '0;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [ibct_pkg::CNT_W-1:0] i_cfg_wdata = '0;

    ibct_req_if req_ch ();
    ibct_rsp_if rsp_ch ();

    inflight_batch_completion_tracker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    always #5 i_clk = ~i_clk;

    // Tracker mirror
    logic [ibct_pkg::CNT_W-1:0] m_limit = '0;
    logic [ibct_pkg::TAG_W-1:0] m_head = '0;
    logic [ibct_pkg::TAG_W-1:0] m_tail = '0;
    logic [ibct_pkg::CNT_W-1:0] m_live = '0;
    logic [2:0]                 m_flags [ibct_pkg::RING_DEPTH];
    logic [ibct_pkg::SEQ_W-1:0] m_end [ibct_pkg::RING_DEPTH];
    logic [ibct_pkg::SEQ_W-1:0] m_written = '0;
    logic [ibct_pkg::SEQ_W-1:0] m_durable = '0;
    logic                       m_err = 1'b0;

    t_track_status due_ring [DUE_DEPTH];
    int            due_wr = 0;
    int            due_rd = 0;
    t_script_row   script [SCRIPT_DEPTH];
    int            n_rows = 0;
    int            errors = 0;
    int            n_results = 0;
    int            cycles = 0;
    bit            quiet = 1'b0;
    bit            hold_rsp = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at result %0d: %s", n_results, msg);
        errors++;
    endtask

    function automatic void due_add(input t_track_status s);
        due_ring[due_wr % DUE_DEPTH] = s;
        due_wr++;
    endfunction

    function automatic t_track_status due_take();
        t_track_status s;
        s = due_ring[due_rd % DUE_DEPTH];
        due_rd++;
        return s;
    endfunction

    function automatic void add_row(input t_script_row row);
        script[n_rows] = row;
        n_rows++;
    endfunction

    function automatic void retire_head();
        for (int n = 0; n < ibct_pkg::RING_DEPTH && m_live > 0; n++) begin
            if (!m_flags[m_head][F_VALID] || !m_flags[m_head][F_WDONE]) break;
            m_written = m_end[m_head];
            if (!m_flags[m_head][F_SDONE]) break;
            m_durable = m_end[m_head];
            m_flags[m_head] = '0;
            m_head = m_head + 1'b1;
            m_live = m_live - 1'b1;
        end
    endfunction

    function automatic t_track_status track_batch(input t_batch_req r);
        t_track_status s;
        bit            full;
        bit            limited;
        s = ALL_CLEAR;
        case (r.op)
            ibct_pkg::OP_SUBMIT: begin
                full    = m_live >= ibct_pkg::RING_DEPTH;
                limited = m_limit != 0 && m_live >= m_limit;
                if (!full && !limited) begin
                    m_end[m_tail]   = r.end_seq;
                    m_flags[m_tail] = 3'b001;
                    s.tag           = m_tail;
                    s.accepted      = 1'b1;
                    m_tail          = m_tail + 1'b1;
                    m_live          = m_live + 1'b1;
                    m_written       = r.end_seq;
                end
            end
            ibct_pkg::OP_COMPLETE: begin
                // Error is raised before the slot lookup
                if (r.st == ibct_pkg::CS_FAILURE || r.st == ibct_pkg::CS_RESERVED) m_err = 1'b1;
                if (m_flags[r.tag][F_VALID]) begin
                    m_flags[r.tag][r.sync ? F_SDONE : F_WDONE] = 1'b1;
                    s.accepted = 1'b1;
                end
                retire_head();
            end
            ibct_pkg::OP_TRUNCATE: begin
                m_written = '0;
                m_durable = '0;
            end
            default: ;
        endcase
        s.written  = m_written;
        s.durable  = m_durable;
        s.inflight = m_live;
        s.err      = m_err;
        return s;
    endfunction

    function automatic t_batch_req random_batch(input int submit_pct);
        t_batch_req r;
        int         k;
        int         s;
        r.end_seq = {$urandom, $urandom};
        r.sync    = 1'($urandom_range(0, 1));
        r.tag     = ibct_pkg::TAG_W'($urandom_range(0, ibct_pkg::RING_DEPTH - 1));
        k = $urandom_range(0, 99);
        if (k < submit_pct) r.op = ibct_pkg::OP_SUBMIT;
        else if (k < 90) r.op = ibct_pkg::OP_COMPLETE;
        else if (k < 95) r.op = ibct_pkg::OP_TRUNCATE;
        else r.op = OP_UNUSED;
        // Aim most completions at live slots so the head keeps retiring
        if (r.op == ibct_pkg::OP_COMPLETE && m_live > 0 && $urandom_range(0, 9) < 8)
            r.tag = m_head + ibct_pkg::TAG_W'($urandom_range(0, int'(m_live) - 1));
        s = $urandom_range(0, 99);
        if (s < 80) r.st = CS_SUCCESS;
        else if (s < 92) r.st = CS_CANCELLED;
        else if (s < 97) r.st = ibct_pkg::CS_FAILURE;
        else r.st = ibct_pkg::CS_RESERVED;
        return r;
    endfunction

    function automatic t_script_row item_row(input logic [ibct_pkg::OP_W-1:0] op,
                                             input logic [ibct_pkg::SEQ_W-1:0] seq,
                                             input logic [ibct_pkg::TAG_W-1:0] tag,
                                             input logic sync,
                                             input logic [ibct_pkg::STATUS_W-1:0] st);
        t_script_row row;
        row.is_cfg = 1'b0;
        row.limit  = '0;
        row.req    = '{op, seq, tag, sync, st};
        row.typed  = 1'b0;
        row.want   = ALL_CLEAR;
        return row;
    endfunction

    function automatic t_script_row typed_row(input t_script_row row, input t_track_status w);
        t_script_row t;
        t       = row;
        t.typed = 1'b1;
        t.want  = w;
        return t;
    endfunction

    function automatic t_script_row cfg_row(input logic [ibct_pkg::CNT_W-1:0] v);
        t_script_row row;
        row        = item_row(OP_UNUSED, '0, '0, 1'b0, CS_SUCCESS);
        row.is_cfg = 1'b1;
        row.limit  = v;
        return row;
    endfunction

    // Offer one item, hold it until taken, then log what it must produce
    task automatic offer(input t_batch_req r, input bit typed, input t_track_status want);
        t_track_status s;
        @(negedge i_clk);
        req_ch.valid             = 1'b1;
        req_ch.opcode            = r.op;
        req_ch.end_seq           = r.end_seq;
        req_ch.slot_tag          = r.tag;
        req_ch.is_sync           = r.sync;
        req_ch.completion_status = r.st;
        do @(posedge i_clk); while (!req_ch.ready);
        s = track_batch(r);
        due_add(typed ? want : s);
    endtask

    task automatic idle_sender(input int n);
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        while (due_wr != due_rd) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [ibct_pkg::CNT_W-1:0] v);
        drain_results();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        m_limit     = v;
    endtask

    task automatic check_status(input t_track_status got);
        t_track_status want;
        if (due_wr == due_rd) begin
            report_mismatch("result with no item waiting");
        end else begin
            want = due_take();
            if (got.accepted !== want.accepted)
                report_mismatch($sformatf("accepted %0b, want %0b", got.accepted, want.accepted));
            if (got.tag !== want.tag)
                report_mismatch($sformatf("assigned_tag %0d, want %0d", got.tag, want.tag));
            if (got.written !== want.written)
                report_mismatch($sformatf("written_mark %h, want %h", got.written, want.written));
            if (got.durable !== want.durable)
                report_mismatch($sformatf("durable_mark %h, want %h", got.durable, want.durable));
            if (got.inflight !== want.inflight)
                report_mismatch($sformatf("inflight_count %0d, want %0d",
                                          got.inflight, want.inflight));
            if (got.err !== want.err)
                report_mismatch($sformatf("error_flag %0b, want %0b", got.err, want.err));
        end
        n_results++;
    endtask

    // Result side: random stalls, one long hold-off on request
    initial begin
        int stall_left;
        int held;
        stall_left   = 0;
        held         = 0;
        rsp_ch.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_rsp) begin
                rsp_ch.ready = 1'b0;
                held++;
                if (held >= HOLD_CYCLES) begin
                    hold_rsp = 1'b0;
                    held     = 0;
                end
            end else if (stall_left > 0) begin
                rsp_ch.ready = 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready = 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 16);
            end
            @(posedge i_clk);
            if (rsp_ch.valid && rsp_ch.ready)
                check_status('{rsp_ch.accepted, rsp_ch.assigned_tag, rsp_ch.written_mark,
                               rsp_ch.durable_mark, rsp_ch.inflight_count,
                               rsp_ch.error_flag});
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("inflight_batch_completion_tracker test failed");
        $finish;
    end

    initial begin
        int phase_limit  [PHASES];
        int phase_submit [PHASES];
        phase_limit  = '{16, 1, 31, 0, 4, 8, 2, 0};
        phase_submit = '{45, 40, 50, 70, 40, 45, 40, 40};

        req_ch.valid             = 1'b0;
        req_ch.opcode            = ibct_pkg::OP_SUBMIT;
        req_ch.end_seq           = '0;
        req_ch.slot_tag          = '0;
        req_ch.is_sync           = 1'b0;
        req_ch.completion_status = CS_SUCCESS;
        for (int i = 0; i < ibct_pkg::RING_DEPTH; i++) begin
            m_flags[i] = '0;
            m_end[i]   = '0;
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Fresh state, unknown opcode, completions to dead slots
        add_row(typed_row(item_row(ibct_pkg::OP_TRUNCATE, SEQ_ONES, 4'd3, 1'b1, CS_SUCCESS),
                          ALL_CLEAR));
        add_row(typed_row(item_row(OP_UNUSED, SEQ_ONES, 4'd15, 1'b1, ibct_pkg::CS_RESERVED),
                          ALL_CLEAR));
        add_row(typed_row(item_row(ibct_pkg::OP_COMPLETE, '0, 4'd5, 1'b0, CS_SUCCESS),
                          ALL_CLEAR));
        // Failure on a dead slot still raises the error
        add_row(typed_row(item_row(ibct_pkg::OP_COMPLETE, '0, 4'd15, 1'b1,
                                   ibct_pkg::CS_FAILURE),
                          '{1'b0, 4'd0, 64'd0, 64'd0, 5'd0, 1'b1}));
        // Sticky error does not refuse submits
        add_row(typed_row(item_row(ibct_pkg::OP_SUBMIT, SEQ_ONES, 4'd9, 1'b0, CS_SUCCESS),
                          '{1'b1, 4'd0, SEQ_ONES, 64'd0, 5'd1, 1'b1}));
        add_row(cfg_row(5'd1));
        add_row(typed_row(item_row(ibct_pkg::OP_SUBMIT, '0, 4'd0, 1'b0, CS_SUCCESS),
                          '{1'b0, 4'd0, SEQ_ONES, 64'd0, 5'd1, 1'b1}));
        add_row(cfg_row(5'd0));
        add_row(item_row(ibct_pkg::OP_SUBMIT, '0, 4'd0, 1'b0, CS_SUCCESS));
        add_row(item_row(ibct_pkg::OP_COMPLETE, '0, 4'd0, 1'b1, CS_SUCCESS));
        add_row(item_row(ibct_pkg::OP_COMPLETE, '0, 4'd0, 1'b0, CS_CANCELLED));
        add_row(item_row(ibct_pkg::OP_COMPLETE, '0, 4'd0, 1'b0, CS_SUCCESS));
        add_row(item_row(ibct_pkg::OP_COMPLETE, '0, 4'd1, 1'b0, ibct_pkg::CS_RESERVED));
        add_row(item_row(ibct_pkg::OP_COMPLETE, '0, 4'd1, 1'b0, CS_SUCCESS));
        add_row(item_row(ibct_pkg::OP_COMPLETE, '0, 4'd1, 1'b1, CS_CANCELLED));
        add_row(item_row(ibct_pkg::OP_TRUNCATE, '0, 4'd0, 1'b0, CS_SUCCESS));
        add_row(item_row(ibct_pkg::OP_SUBMIT, {32{2'b10}}, 4'd0, 1'b0, CS_SUCCESS));
        add_row(item_row(ibct_pkg::OP_SUBMIT, {32{2'b01}}, 4'd0, 1'b0, CS_SUCCESS));
        // Out of order: sync first, then a later slot, then the head write
        add_row(item_row(ibct_pkg::OP_COMPLETE, '0, 4'd2, 1'b1, ibct_pkg::CS_FAILURE));
        add_row(item_row(ibct_pkg::OP_COMPLETE, '0, 4'd3, 1'b0, CS_SUCCESS));
        add_row(item_row(ibct_pkg::OP_COMPLETE, '0, 4'd2, 1'b0, CS_SUCCESS));
        add_row(item_row(ibct_pkg::OP_TRUNCATE, '0, 4'd0, 1'b0, CS_SUCCESS));
        add_row(item_row(OP_UNUSED, {$urandom, $urandom}, ibct_pkg::TAG_W'($urandom),
                         1'b1, CS_CANCELLED));

        for (int i = 0; i < n_rows; i++) begin
            if (script[i].is_cfg) write_limit(script[i].limit);
            else offer(script[i].req, script[i].typed, script[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            write_limit(ibct_pkg::CNT_W'(phase_limit[p]));
            quiet = (p == PHASES - 1);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (p == 4 && i == 10) hold_rsp = 1'b1;
                if (p == 5 && i == 25) drain_results();
                if (!quiet && $urandom_range(0, 7) == 0) idle_sender($urandom_range(1, 16));
                offer(random_batch(phase_submit[p]), 1'b0, ALL_CLEAR);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (due_wr != due_rd) report_mismatch("results still missing at the end");
        if (errors == 0) begin
            $display("inflight_batch_completion_tracker test passed");
        end else begin
            $display("inflight_batch_completion_tracker test failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/ibct_pkg.sv
hw/rtl/ibct_if.sv
hw/rtl/ibct_slot_store.sv
hw/rtl/inflight_batch_completion_tracker.sv
bench/tb_inflight_batch_completion_tracker.sv
